[rtl/ilist_pkg.sv]
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared constants, codes and controller/datapath command types for the
// indexed list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilist_pkg;

  localparam int CAPACITY = 256;
  localparam int ELEM_W   = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_READ    = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_REVERSE = 3'd4
  } ilist_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } ilist_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_INS_WR,
    S_SHIFT_DN,
    S_READ_WAIT,
    S_SEARCH,
    S_REV_RD,
    S_REV_WLO,
    S_REV_WHI,
    S_FINISH
  } ilist_state_t;

  // index register update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } ilist_idx_op_t;

  // read port A address
  typedef enum logic [1:0] {
    RA_IDX,
    RA_UP,
    RA_DN,
    RA_POS
  } ilist_ra_sel_t;

  // explicit write source (the shift pipeline writes on its own)
  typedef enum logic [1:0] {
    WR_NONE,
    WR_INS,
    WR_LO,
    WR_HI
  } ilist_wr_sel_t;

  typedef struct packed {
    logic          capture;
    logic          set_status;
    ilist_status_t status_val;
    ilist_idx_op_t idx_op;
    logic          hi_load;
    logic          hi_dec;
    logic          rd_en;
    ilist_ra_sel_t ra_sel;
    logic          rdb_en;
    logic          move;
    logic          search;
    ilist_wr_sel_t wr_sel;
    logic          cnt_inc;
    logic          cnt_dec;
    logic          load_read;
    logic          set_found;
    logic          load_result;
  } ilist_cmd_t;

  typedef struct packed {
    ilist_op_t op;
    logic      full;
    logic      pos_le_cnt;
    logic      pos_lt_cnt;
    logic      cnt_gt1;
    logic      idx_gt_pos;
    logic      idx_inc_lt_cnt;
    logic      idx_lt_cnt;
    logic      cmp_v;
    logic      hit;
    logic      lo_lt_hi;
  } ilist_sts_t;

endpackage

`default_nettype wire

[rtl/ilist_ifs.sv]
// ----------------------------------------------------------------------------
// ilist_ifs
// Valid/ready channel interfaces for list requests and list responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ilist_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ilist_pkg::OP_W-1:0]    operation;
  logic        [ilist_pkg::CNT_W-1:0]   position;
  logic signed [ilist_pkg::ELEM_W-1:0]  element_value;

  modport source (output valid, operation, position, element_value, input ready);
  modport sink   (input valid, operation, position, element_value, output ready);
endinterface

interface ilist_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic        [ilist_pkg::STATUS_W-1:0] status;
  logic signed [ilist_pkg::ELEM_W-1:0]   read_value;
  logic        [ilist_pkg::ADDR_W-1:0]   found_position;
  logic                                  found;
  logic        [ilist_pkg::CNT_W-1:0]    list_length;
  logic                                  list_empty;

  modport source (output valid, status, read_value, found_position, found, list_length,
                  list_empty, input ready);
  modport sink   (input valid, status, read_value, found_position, found, list_length,
                  list_empty, output ready);
endinterface

`default_nettype wire

[rtl/ilist_dp.sv]
// ----------------------------------------------------------------------------
// ilist_dp
// Datapath: element store (one write, two read ports), count, index
// registers, shift and search pipelines, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilist_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic        [ilist_pkg::OP_W-1:0]    operation,
  input  logic        [ilist_pkg::CNT_W-1:0]   position,
  input  logic signed [ilist_pkg::ELEM_W-1:0]  element_value,
  input  ilist_pkg::ilist_cmd_t                cmd,
  output ilist_pkg::ilist_sts_t                sts,
  output logic        [ilist_pkg::STATUS_W-1:0] status,
  output logic signed [ilist_pkg::ELEM_W-1:0]  read_value,
  output logic        [ilist_pkg::ADDR_W-1:0]  found_position,
  output logic                                 found,
  output logic        [ilist_pkg::CNT_W-1:0]   list_length,
  output logic                                 list_empty
);

  logic [ilist_pkg::ELEM_W-1:0] mem [ilist_pkg::CAPACITY];

  ilist_pkg::ilist_op_t          op;
  logic [ilist_pkg::CNT_W-1:0]   pos;
  logic [ilist_pkg::ELEM_W-1:0]  val;
  logic [ilist_pkg::CNT_W-1:0]   count;
  logic [ilist_pkg::CNT_W-1:0]   idx;
  logic [ilist_pkg::ADDR_W-1:0]  hi;
  logic [ilist_pkg::ELEM_W-1:0]  rd_a;
  logic [ilist_pkg::ELEM_W-1:0]  rd_b;
  logic                          pend_v;
  logic [ilist_pkg::ADDR_W-1:0]  pend_addr;
  logic                          cmp_v;
  logic [ilist_pkg::ADDR_W-1:0]  cmp_addr;

  ilist_pkg::ilist_status_t      stat;
  logic [ilist_pkg::ELEM_W-1:0]  rdval;
  logic [ilist_pkg::ADDR_W-1:0]  fpos;
  logic                          fnd;

  logic [ilist_pkg::CNT_W-1:0]   idx_m1;
  logic [ilist_pkg::CNT_W-1:0]   idx_p1;
  logic [ilist_pkg::CNT_W-1:0]   cnt_m1;
  logic [ilist_pkg::ADDR_W-1:0]  ra;
  logic                          we;
  logic [ilist_pkg::ADDR_W-1:0]  wa;
  logic [ilist_pkg::ELEM_W-1:0]  wd;

  assign idx_m1 = idx - 1'b1;
  assign idx_p1 = idx + 1'b1;
  assign cnt_m1 = count - 1'b1;

  always_comb begin
    case (cmd.ra_sel)
      ilist_pkg::RA_IDX: ra = idx[ilist_pkg::ADDR_W-1:0];
      ilist_pkg::RA_UP:  ra = idx_m1[ilist_pkg::ADDR_W-1:0];
      ilist_pkg::RA_DN:  ra = idx_p1[ilist_pkg::ADDR_W-1:0];
      ilist_pkg::RA_POS: ra = pos[ilist_pkg::ADDR_W-1:0];
      default:           ra = idx[ilist_pkg::ADDR_W-1:0];
    endcase
  end

  // shift pipeline write lands in the cycle after its read
  always_comb begin
    we = pend_v;
    wa = pend_addr;
    wd = rd_a;
    case (cmd.wr_sel)
      ilist_pkg::WR_INS: begin
        we = 1'b1;
        wa = pos[ilist_pkg::ADDR_W-1:0];
        wd = val;
      end
      ilist_pkg::WR_LO: begin
        we = 1'b1;
        wa = idx[ilist_pkg::ADDR_W-1:0];
        wd = rd_b;
      end
      ilist_pkg::WR_HI: begin
        we = 1'b1;
        wa = hi;
        wd = rd_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rd_a <= mem[ra];
    end
    if (cmd.rdb_en) begin
      rd_b <= mem[hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      pend_v <= 1'b0;
      cmp_v  <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= cnt_m1;
      end
      pend_v <= cmd.move;
      cmp_v  <= cmd.search;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= ilist_pkg::ilist_op_t'(operation);
      pos   <= position;
      val   <= element_value;
      stat  <= ilist_pkg::ST_OK;
      rdval <= '0;
      fpos  <= '0;
      fnd   <= 1'b0;
    end
    if (cmd.set_status) begin
      stat <= cmd.status_val;
    end
    if (cmd.load_read) begin
      rdval <= rd_a;
    end
    if (cmd.set_found) begin
      stat <= ilist_pkg::ST_OK;
      fpos <= cmp_addr;
      fnd  <= 1'b1;
    end
    if (cmd.move) begin
      pend_addr <= idx[ilist_pkg::ADDR_W-1:0];
    end
    if (cmd.search) begin
      cmp_addr <= idx[ilist_pkg::ADDR_W-1:0];
    end
    case (cmd.idx_op)
      ilist_pkg::IDX_CNT:  idx <= count;
      ilist_pkg::IDX_POS:  idx <= pos;
      ilist_pkg::IDX_ZERO: idx <= '0;
      ilist_pkg::IDX_INC:  idx <= idx_p1;
      ilist_pkg::IDX_DEC:  idx <= idx_m1;
      default: ;
    endcase
    if (cmd.hi_load) begin
      hi <= cnt_m1[ilist_pkg::ADDR_W-1:0];
    end else if (cmd.hi_dec) begin
      hi <= hi - 1'b1;
    end
    if (cmd.load_result) begin
      status         <= stat;
      read_value     <= rdval;
      found_position <= fpos;
      found          <= fnd;
      list_length    <= count;
      list_empty     <= (count == '0);
    end
  end

  always_comb begin
    sts.op             = op;
    sts.full           = (count == ilist_pkg::CNT_W'(ilist_pkg::CAPACITY));
    sts.pos_le_cnt     = (pos <= count);
    sts.pos_lt_cnt     = (pos < count);
    sts.cnt_gt1        = (count > ilist_pkg::CNT_W'(1));
    sts.idx_gt_pos     = (idx > pos);
    sts.idx_inc_lt_cnt = (idx_p1 < count);
    sts.idx_lt_cnt     = (idx < count);
    sts.cmp_v          = cmp_v;
    sts.hit            = cmp_v && (rd_a == val);
    sts.lo_lt_hi       = (idx < ilist_pkg::CNT_W'(hi));
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(pend_v && (cmd.wr_sel != ilist_pkg::WR_NONE)))
    else $error("shift write collides with another store write");

  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count < ilist_pkg::CNT_W'(ilist_pkg::CAPACITY)))
    else $error("count grows past capacity");

  a_dec_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |=> (count == $past(cnt_m1)) && ($past(count) != '0))
    else $error("count shrinks from empty");

endmodule

`default_nettype wire

[rtl/ilist_ctrl.sv]
// ----------------------------------------------------------------------------
// ilist_ctrl
// Controller: sequences each operation over the datapath and owns the
// request ready and the response valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilist_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ilist_pkg::ilist_sts_t sts,
  output ilist_pkg::ilist_cmd_t cmd
);

  ilist_pkg::ilist_state_t state;
  ilist_pkg::ilist_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ilist_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ilist_pkg::S_IDLE: begin
        // hold off requests while reset is asserted
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ilist_pkg::S_DECODE;
        end
      end
      ilist_pkg::S_DECODE: begin
        state_next = ilist_pkg::S_FINISH;
        case (sts.op)
          ilist_pkg::OP_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ilist_pkg::ST_FULL;
            end else if (!sts.pos_le_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ilist_pkg::ST_RANGE;
            end else begin
              cmd.idx_op = ilist_pkg::IDX_CNT;
              state_next = ilist_pkg::S_SHIFT_UP;
            end
          end
          ilist_pkg::OP_DELETE: begin
            if (!sts.pos_lt_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ilist_pkg::ST_RANGE;
            end else begin
              cmd.idx_op = ilist_pkg::IDX_POS;
              state_next = ilist_pkg::S_SHIFT_DN;
            end
          end
          ilist_pkg::OP_READ: begin
            if (!sts.pos_lt_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ilist_pkg::ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.ra_sel = ilist_pkg::RA_POS;
              state_next = ilist_pkg::S_READ_WAIT;
            end
          end
          ilist_pkg::OP_SEARCH: begin
            cmd.set_status = 1'b1;
            cmd.status_val = ilist_pkg::ST_NOTFOUND;
            cmd.idx_op     = ilist_pkg::IDX_ZERO;
            state_next     = ilist_pkg::S_SEARCH;
          end
          ilist_pkg::OP_REVERSE: begin
            if (sts.cnt_gt1) begin
              cmd.idx_op  = ilist_pkg::IDX_ZERO;
              cmd.hi_load = 1'b1;
              state_next  = ilist_pkg::S_REV_RD;
            end
          end
          default: ;
        endcase
      end
      ilist_pkg::S_SHIFT_UP: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = ilist_pkg::RA_UP;
          cmd.move   = 1'b1;
          cmd.idx_op = ilist_pkg::IDX_DEC;
        end else begin
          state_next = ilist_pkg::S_INS_WR;
        end
      end
      ilist_pkg::S_INS_WR: begin
        cmd.wr_sel  = ilist_pkg::WR_INS;
        cmd.cnt_inc = 1'b1;
        state_next  = ilist_pkg::S_FINISH;
      end
      ilist_pkg::S_SHIFT_DN: begin
        if (sts.idx_inc_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = ilist_pkg::RA_DN;
          cmd.move   = 1'b1;
          cmd.idx_op = ilist_pkg::IDX_INC;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = ilist_pkg::S_FINISH;
        end
      end
      ilist_pkg::S_READ_WAIT: begin
        cmd.load_read = 1'b1;
        state_next    = ilist_pkg::S_FINISH;
      end
      ilist_pkg::S_SEARCH: begin
        if (sts.hit) begin
          cmd.set_found = 1'b1;
          state_next    = ilist_pkg::S_FINISH;
        end else if (sts.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = ilist_pkg::RA_IDX;
          cmd.search = 1'b1;
          cmd.idx_op = ilist_pkg::IDX_INC;
        end else if (!sts.cmp_v) begin
          state_next = ilist_pkg::S_FINISH;
        end
      end
      ilist_pkg::S_REV_RD: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = ilist_pkg::RA_IDX;
          cmd.rdb_en = 1'b1;
          state_next = ilist_pkg::S_REV_WLO;
        end else begin
          state_next = ilist_pkg::S_FINISH;
        end
      end
      ilist_pkg::S_REV_WLO: begin
        cmd.wr_sel = ilist_pkg::WR_LO;
        state_next = ilist_pkg::S_REV_WHI;
      end
      ilist_pkg::S_REV_WHI: begin
        cmd.wr_sel = ilist_pkg::WR_HI;
        cmd.idx_op = ilist_pkg::IDX_INC;
        cmd.hi_dec = 1'b1;
        state_next = ilist_pkg::S_REV_RD;
      end
      ilist_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_result = 1'b1;
          state_next      = ilist_pkg::S_IDLE;
        end
      end
      default: state_next = ilist_pkg::S_IDLE;
    endcase
  end

  a_rsp_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !cmd.load_result) |=> !out_valid)
    else $error("response stays valid after its transfer");

endmodule

`default_nettype wire

[rtl/indexed_list_insert_delete_engine.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_engine
// Ordered list of signed elements in a fixed store with insert, delete,
// read, search and reverse; one response per request.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next request is taken as soon as the
// engine is back in idle, even while the previous response still sits in the
// output register. Refused, out-of-range and ignored requests and reverse of
// a list shorter than two go from decode straight to the response. Shifts
// move one element per cycle and reverse swaps one pair at a time, reading
// both ends and then writing the low and then the high entry, both set by the
// single write port of the element store. The store has no reset and no
// clearing pass: only entries below the length are ever read, and each of
// those has been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete_engine (
  input  logic        clk,
  input  logic        rst,
  ilist_req_if.sink   req,
  ilist_rsp_if.source rsp
);

  ilist_pkg::ilist_cmd_t cmd;
  ilist_pkg::ilist_sts_t sts;

  // controller: walks each operation, one datapath command word per cycle
  ilist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: store, count, index registers and the response register that
  // drives the response payload directly
  ilist_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .operation      (req.operation),
    .position       (req.position),
    .element_value  (req.element_value),
    .cmd            (cmd),
    .sts            (sts),
    .status         (rsp.status),
    .read_value     (rsp.read_value),
    .found_position (rsp.found_position),
    .found          (rsp.found),
    .list_length    (rsp.list_length),
    .list_empty     (rsp.list_empty)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed list engine. Requests go in over the
// valid/ready request channel with random gaps; responses come back under
// random back-pressure. A local copy of the list predicts every response,
// and the responses are checked field by field, in order. A directed pass
// covers empty, single-element, full and out-of-range cases, and random
// passes then fill, drain and churn the list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ilist_pkg::*;

  // Operation codes the block ignores; they still return one response.
  localparam logic [OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_MID   = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_LAST  = 3'd7;

  // Worst case is about 2000 requests, each up to a full-list shift or search,
  // plus gaps and stalls; allow several times that before giving up.
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int MAX_PRINTED   = 50;
  localparam int POSITION_MAX  = (1 << CNT_W) - 1;

  typedef struct packed {
    ilist_status_t             status;
    logic signed [ELEM_W-1:0]  read_value;
    logic [ADDR_W-1:0]         found_position;
    logic                      found;
    logic [CNT_W-1:0]          list_length;
    logic                      list_empty;
  } list_result_t;

  logic clk;
  logic rst;

  ilist_req_if req_ch ();
  ilist_rsp_if rsp_ch ();

  indexed_list_insert_delete_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list: only entries below list_len are meaningful.
  logic signed [ELEM_W-1:0] list_mem [CAPACITY];
  int                       list_len;

  list_result_t pending_results [$];
  int           error_count;
  int           cycle_count;
  bit           source_steady;
  bit           sink_steady;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line per failure, quiet after the first few.
  // --------------------------------------------------------------------------
  task automatic report_error(input string what);
    if (error_count < MAX_PRINTED)
      $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // List predictor: apply one request to the shadow list and build the
  // response the engine must return.
  // --------------------------------------------------------------------------
  function automatic list_result_t predict_list_op(input logic [OP_W-1:0] op,
                                                   input logic [CNT_W-1:0] pos,
                                                   input logic signed [ELEM_W-1:0] val);
    list_result_t             res;
    int                       k;
    int                       lo;
    int                       hi;
    logic signed [ELEM_W-1:0] swap;
    res        = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        // Full is checked before the index.
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (int'(pos) > list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (k = list_len; k > int'(pos); k--)
            list_mem[ADDR_W'(k)] = list_mem[ADDR_W'(k-1)];
          list_mem[pos[ADDR_W-1:0]] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (int'(pos) >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (k = int'(pos); k + 1 < list_len; k++)
            list_mem[ADDR_W'(k)] = list_mem[ADDR_W'(k+1)];
          list_len--;
        end
      end
      OP_READ: begin
        if (int'(pos) >= list_len)
          res.status = ST_RANGE;
        else
          res.read_value = list_mem[pos[ADDR_W-1:0]];
      end
      OP_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (list_mem[ADDR_W'(k)] == val) begin
            res.status         = ST_OK;
            res.found          = 1'b1;
            res.found_position = ADDR_W'(k);
            break;
          end
        end
      end
      OP_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (lo < hi) begin
          swap                  = list_mem[ADDR_W'(lo)];
          list_mem[ADDR_W'(lo)] = list_mem[ADDR_W'(hi)];
          list_mem[ADDR_W'(hi)] = swap;
          lo++;
          hi--;
        end
      end
      default: ;
    endcase
    res.list_length = CNT_W'(list_len);
    res.list_empty  = (list_len == 0);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: idle a random number of cycles, then hold the request
  // until the transfer and queue its predicted response.
  // --------------------------------------------------------------------------
  task automatic transfer_request(input logic [OP_W-1:0] op,
                                  input logic [CNT_W-1:0] pos,
                                  input logic signed [ELEM_W-1:0] val);
    int gap;
    // Flip now and then between idling and back-to-back stretches.
    if ($urandom_range(0, 39) == 0)
      source_steady = !source_steady;
    gap = source_steady ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.position      <= pos;
    req_ch.element_value <= val;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    pending_results.push_back(predict_list_op(op, pos, val));
  endtask

  // Values drawn partly from a small pool so searches hit duplicates.
  function automatic logic signed [ELEM_W-1:0] pick_value();
    logic signed [ELEM_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 7))
        0: v = 32'sh0000_0000;
        1: v = -32'sd1;
        2: v = 32'sh7fff_ffff;
        3: v = 32'sh8000_0000;
        4: v = 32'sh5555_5555;
        5: v = 32'shaaaa_aaaa;
        6: v = 32'sd1;
        default: v = 32'sd7;
      endcase
    end
    return v;
  endfunction

  // Pick a position inside the list most of the time, ends favored, with a
  // share of arbitrary positions that are usually out of range.
  function automatic logic [CNT_W-1:0] pick_position(input int span);
    int roll;
    roll = $urandom_range(0, 9);
    if (span <= 0 || roll == 0)
      return CNT_W'($urandom_range(0, POSITION_MAX));
    if (roll == 1)
      return '0;
    if (roll == 2)
      return CNT_W'(span - 1);
    return CNT_W'($urandom_range(0, span - 1));
  endfunction

  // One random request with the given operation weights.
  task automatic issue_random(input int w_ins, input int w_del, input int w_rd,
                              input int w_srch, input int w_rev);
    int                       roll;
    logic [OP_W-1:0]          op;
    logic [CNT_W-1:0]         pos;
    logic signed [ELEM_W-1:0] val;
    roll = $urandom_range(0, w_ins + w_del + w_rd + w_srch + w_rev - 1);
    if (roll < w_ins)                               op = OP_INSERT;
    else if (roll < w_ins + w_del)                  op = OP_DELETE;
    else if (roll < w_ins + w_del + w_rd)           op = OP_READ;
    else if (roll < w_ins + w_del + w_rd + w_srch)  op = OP_SEARCH;
    else                                            op = OP_REVERSE;
    if ($urandom_range(0, 99) == 0)
      op = OP_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
    val = pick_value();
    case (op)
      OP_INSERT: pos = pick_position(list_len + 1);
      OP_DELETE, OP_READ: pos = pick_position(list_len);
      default: pos = CNT_W'($urandom_range(0, POSITION_MAX));
    endcase
    // Search mostly for a value that is held somewhere in the list.
    if (op == OP_SEARCH && list_len > 0 && $urandom_range(0, 9) < 7)
      val = list_mem[ADDR_W'($urandom_range(0, list_len - 1))];
    transfer_request(op, pos, val);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every operation on an empty list, plus the ignored codes.
  task automatic test_empty_list();
    transfer_request(OP_READ,    '0, '0);
    transfer_request(OP_DELETE,  '0, '0);
    transfer_request(OP_SEARCH,  '0, '0);
    transfer_request(OP_REVERSE, '0, '0);
    transfer_request(OP_INSERT,  9'd1, 32'sd5);
    transfer_request(OP_UNDEF_FIRST, 9'd3, 32'sd9);
    transfer_request(OP_UNDEF_MID, '0, -32'sd1);
    transfer_request(OP_UNDEF_LAST, 9'd511, 32'sh8000_0000);
  endtask

  // Small list: inserts at both ends, extreme values, reverse, search hit and
  // miss, reads and deletes in and out of range.
  task automatic test_basic_ops();
    transfer_request(OP_INSERT,  '0,     32'sh7fff_ffff);
    transfer_request(OP_REVERSE, '0,     '0);
    transfer_request(OP_INSERT,  9'd1,   32'sh8000_0000);
    transfer_request(OP_INSERT,  '0,     -32'sd1);
    transfer_request(OP_INSERT,  9'd1,   '0);
    transfer_request(OP_READ,    '0,     '0);
    transfer_request(OP_READ,    9'd3,   '0);
    transfer_request(OP_READ,    9'd4,   '0);
    transfer_request(OP_SEARCH,  9'd511, 32'sh8000_0000);
    transfer_request(OP_SEARCH,  '0,     32'sd12345);
    transfer_request(OP_REVERSE, '0,     '0);
    transfer_request(OP_READ,    '0,     '0);
    transfer_request(OP_DELETE,  9'd3,   '0);
    transfer_request(OP_DELETE,  '0,     '0);
    transfer_request(OP_DELETE,  9'd511, '0);
    transfer_request(OP_INSERT,  9'd256, 32'sd3);
  endtask

  // Grow the list to capacity, then push at the full boundary.
  task automatic test_fill_capacity();
    while (list_len < CAPACITY)
      issue_random(85, 4, 5, 4, 2);
    transfer_request(OP_INSERT,  9'd256, 32'sd11);
    transfer_request(OP_INSERT,  9'd300, 32'sd12);
    transfer_request(OP_READ,    9'd255, '0);
    transfer_request(OP_READ,    9'd256, '0);
    transfer_request(OP_SEARCH,  '0,     list_mem[CAPACITY-1]);
    transfer_request(OP_REVERSE, '0,     '0);
    transfer_request(OP_DELETE,  9'd255, '0);
    transfer_request(OP_INSERT,  9'd255, 32'sh8000_0000);
    transfer_request(OP_INSERT,  '0,     32'sd13);
    repeat (20)
      issue_random(40, 10, 20, 20, 10);
  endtask

  // Shrink the list back to empty under a delete-heavy mix.
  task automatic test_drain_list();
    while (list_len > 0)
      issue_random(5, 80, 6, 6, 3);
  endtask

  // Keep the list short so empty and one-element cases recur often.
  task automatic test_short_list(input int count);
    repeat (count) begin
      if (list_len < 3)
        issue_random(60, 10, 10, 15, 5);
      else if (list_len > 12)
        issue_random(10, 60, 10, 15, 5);
      else
        issue_random(30, 30, 15, 20, 5);
    end
  endtask

  // Balanced mix; the list wanders through all lengths.
  task automatic test_mixed_ops(input int count);
    repeat (count)
      issue_random(35, 25, 18, 17, 5);
  endtask

  // --------------------------------------------------------------------------
  // Response sink: stall a random number of cycles per response, then hold
  // ready high until the transfer.
  // --------------------------------------------------------------------------
  initial begin : response_sink
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0)
        sink_steady = !sink_steady;
      stall = sink_steady ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid)
        @(posedge clk);
    end
  end

  // Compare every response transfer against the oldest prediction.
  always @(posedge clk) begin : response_check
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_error("response with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_error($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
        if (rsp_ch.read_value !== want.read_value)
          report_error($sformatf("read_value got %0h want %0h",
                                 rsp_ch.read_value, want.read_value));
        if (rsp_ch.found_position !== want.found_position)
          report_error($sformatf("found_position got %0d want %0d",
                                 rsp_ch.found_position, want.found_position));
        if (rsp_ch.found !== want.found)
          report_error($sformatf("found got %0b want %0b", rsp_ch.found, want.found));
        if (rsp_ch.list_length !== want.list_length)
          report_error($sformatf("list_length got %0d want %0d",
                                 rsp_ch.list_length, want.list_length));
        if (rsp_ch.list_empty !== want.list_empty)
          report_error($sformatf("list_empty got %0b want %0b",
                                 rsp_ch.list_empty, want.list_empty));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.operation     = '0;
    req_ch.position      = '0;
    req_ch.element_value = '0;
    list_len             = 0;
    error_count          = 0;
    cycle_count          = 0;
    source_steady        = 1'b0;
    sink_steady          = 1'b0;

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_basic_ops();
    test_short_list(650);
    test_fill_capacity();
    test_drain_list();
    test_mixed_ops(550);

    // Drop valid after the last transfer, then wait out every response.
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    // Leave room for any stray response to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[indexed_list_insert_delete_engine.f]
rtl/ilist_pkg.sv
rtl/ilist_ifs.sv
rtl/ilist_dp.sv
rtl/ilist_ctrl.sv
rtl/indexed_list_insert_delete_engine.sv
tb/testbench.sv
